@@ rtl/rdb_pkg.sv @@
// Shared types, constants and helper functions for the retry decision and backoff block.
package rdb_pkg;

    localparam int DELAY_BITS_DEF       = 24;
    localparam int FACTOR_FRAC_BITS_DEF = 8;
    localparam int LFSR_BITS_DEF        = 16;

    localparam int CLASS_BITS     = 4;
    localparam int ATTEMPT_BITS   = 8;
    localparam int LIMIT_BITS     = 8;
    localparam int BASE_BITS      = 16;
    localparam int FACTOR_BITS    = 12;
    localparam int WAIT_BITS      = 24;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_OTHER,
        CLS_TRANSPORT,
        CLS_SLOW_DOWN,
        CLS_UNAVAILABLE,
        CLS_HTTP_500,
        CLS_HTTP_502,
        CLS_HTTP_503,
        CLS_HTTP_504,
        CLS_TIMEOUT,
        CLS_REQ_TIMEOUT,
        CLS_CONN_FAILED
    } failure_class_e;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RETRY_LIMIT,
        REG_THROTTLE_ENABLE,
        REG_SERVER_ERROR_ENABLE,
        REG_TIMEOUT_ENABLE,
        REG_BASE_DELAY,
        REG_GROWTH_FACTOR,
        REG_DELAY_CEILING,
        REG_JITTER_ENABLE
    } cfg_index_e;

    typedef struct packed {
        logic [LIMIT_BITS-1:0]  retry_limit;
        logic                   throttle_enable;
        logic                   server_error_enable;
        logic                   timeout_enable;
        logic [BASE_BITS-1:0]   base_delay;
        logic [FACTOR_BITS-1:0] growth_factor;
        logic [WAIT_BITS-1:0]   delay_ceiling;
        logic                   jitter_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        retry_limit:         8'd3,
        throttle_enable:     1'b1,
        server_error_enable: 1'b1,
        timeout_enable:      1'b1,
        base_delay:          16'd100,
        growth_factor:       12'd512,
        delay_ceiling:       24'd20000,
        jitter_enable:       1'b1
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_JITTER,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic cap;
        logic jitter;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic steps_done;
    } status_t;

    function automatic logic class_retries(input logic [CLASS_BITS-1:0] cls, input cfg_t cfg);
        logic ok;
        ok = 1'b0;
        case (cls)
            CLS_TRANSPORT:                   ok = 1'b1;
            CLS_SLOW_DOWN, CLS_UNAVAILABLE:  ok = cfg.throttle_enable;
            CLS_HTTP_500, CLS_HTTP_502,
            CLS_HTTP_503, CLS_HTTP_504:      ok = cfg.server_error_enable;
            CLS_TIMEOUT, CLS_REQ_TIMEOUT,
            CLS_CONN_FAILED:                 ok = cfg.timeout_enable;
            default:                         ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Galois feedback taps for a maximal-length sequence of the given width.
    function automatic logic [31:0] lfsr_feedback(input int width);
        logic [31:0] fb;
        fb = 32'h0;
        case (width)
            8:       fb = 32'h0000_00B8;
            9:       fb = 32'h0000_0110;
            10:      fb = 32'h0000_0240;
            11:      fb = 32'h0000_0500;
            12:      fb = 32'h0000_0829;
            13:      fb = 32'h0000_100D;
            14:      fb = 32'h0000_2015;
            15:      fb = 32'h0000_6000;
            16:      fb = 32'h0000_B400;
            17:      fb = 32'h0001_2000;
            18:      fb = 32'h0002_0400;
            19:      fb = 32'h0004_0023;
            20:      fb = 32'h0009_0000;
            21:      fb = 32'h0014_0000;
            22:      fb = 32'h0030_0000;
            23:      fb = 32'h0042_0000;
            24:      fb = 32'h00E1_0000;
            25:      fb = 32'h0120_0000;
            26:      fb = 32'h0200_0023;
            27:      fb = 32'h0400_0013;
            28:      fb = 32'h0900_0000;
            29:      fb = 32'h1400_0000;
            30:      fb = 32'h2000_0029;
            31:      fb = 32'h4800_0000;
            32:      fb = 32'h8020_0003;
            default: fb = 32'h0;
        endcase
        return fb;
    endfunction

endpackage

@@ rtl/rdb_ctrl.sv @@
// Controller state machine that sequences load, growth steps, capping, jitter and output.
module rdb_ctrl
    import rdb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    output logic    result_valid,
    input  logic    result_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.steps_done)
                begin
                    state_next = ST_JITTER;
                end
            end
            ST_JITTER:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        item_stall     = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.load   = item_valid;
            end
            ST_STEP:
            begin
                cmd.step = !status.steps_done;
                cmd.cap  = status.steps_done;
            end
            ST_JITTER:
            begin
                cmd.jitter = 1'b1;
            end
            ST_DONE:
            begin
                cmd.out_load = !out_valid_reg || !result_stall;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == ST_STEP))
        else $error("accepted beat did not start the growth steps");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the completion state");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid || !result_stall))
        else $error("output register loaded while holding a stalled beat");
`endif

endmodule

@@ rtl/rdb_datapath.sv @@
// Datapath: retry decision, iterative backoff multiply, ceiling cap, LFSR jitter and result registers.
module rdb_datapath
    import rdb_pkg::*;
#(
    parameter int DELAY_BITS       = DELAY_BITS_DEF,
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF,
    parameter int LFSR_BITS        = LFSR_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic [CLASS_BITS-1:0]   failure_class,
    input  logic [ATTEMPT_BITS-1:0] attempt_number,
    output logic                    retry_allowed,
    output logic [WAIT_BITS-1:0]    wait_ms
);

    localparam int PROD_BITS = DELAY_BITS + FACTOR_BITS;
    localparam int CMP_BITS  = (DELAY_BITS > WAIT_BITS) ? DELAY_BITS : WAIT_BITS;
    localparam int JIT_BITS  = WAIT_BITS + LFSR_BITS + 1;
    localparam logic [LFSR_BITS-1:0] LFSR_FB     = LFSR_BITS'(lfsr_feedback(LFSR_BITS));
    localparam logic [LFSR_BITS-1:0] SEED_MASKED = LFSR_SEED[LFSR_BITS-1:0];
    localparam logic [LFSR_BITS-1:0] SEED =
        (SEED_MASKED == '0) ? LFSR_BITS'(1) : SEED_MASKED;

    logic [DELAY_BITS-1:0]   delay_reg;
    logic [DELAY_BITS-1:0]   delay_next;
    logic                    sat_reg;
    logic                    sat_next;
    logic [ATTEMPT_BITS-1:0] count_reg;
    logic [ATTEMPT_BITS-1:0] count_next;
    logic                    decision_reg;
    logic                    decision_next;
    logic [WAIT_BITS-1:0]    capped_reg;
    logic [WAIT_BITS-1:0]    capped_next;
    logic [WAIT_BITS-1:0]    wait_reg;
    logic [WAIT_BITS-1:0]    wait_next;
    logic [LFSR_BITS-1:0]    lfsr_reg;
    logic [LFSR_BITS-1:0]    lfsr_next;
    logic                    retry_allowed_reg;
    logic [WAIT_BITS-1:0]    wait_ms_reg;

    logic [PROD_BITS-1:0]    product;
    logic [PROD_BITS-1:0]    scaled;
    logic                    overflow;
    logic [CMP_BITS-1:0]     delay_ext;
    logic [CMP_BITS-1:0]     ceiling_ext;
    logic [LFSR_BITS-1:0]    lfsr_shifted;
    logic [JIT_BITS-1:0]     jitter_sum;

    // One growth step: multiply by the factor, drop the fraction bits, saturate.
    always_comb
    begin
        product  = PROD_BITS'(delay_reg) * PROD_BITS'(cfg.growth_factor);
        scaled   = product >> FACTOR_FRAC_BITS;
        overflow = (scaled[PROD_BITS-1:DELAY_BITS] != '0);
    end

    always_comb
    begin
        delay_ext   = CMP_BITS'(delay_reg);
        ceiling_ext = CMP_BITS'(cfg.delay_ceiling);
        if (delay_ext > ceiling_ext)
        begin
            capped_next = cfg.delay_ceiling;
        end
        else
        begin
            capped_next = delay_ext[WAIT_BITS-1:0];
        end
    end

    always_comb
    begin
        lfsr_shifted = lfsr_reg >> 1;
        if (lfsr_reg[0])
        begin
            lfsr_shifted = lfsr_shifted ^ LFSR_FB;
        end
        if (lfsr_shifted == '0)
        begin
            lfsr_shifted = SEED;
        end
    end

    // The jitter factor is (2^L + lfsr) / 2^(L+1), with the quotient truncated.
    always_comb
    begin
        jitter_sum = (JIT_BITS'(capped_reg) << LFSR_BITS)
                   + JIT_BITS'(capped_reg) * JIT_BITS'(lfsr_reg);
    end

    always_comb
    begin
        delay_next    = delay_reg;
        sat_next      = sat_reg;
        count_next    = count_reg;
        decision_next = decision_reg;
        if (cmd.load)
        begin
            delay_next    = DELAY_BITS'(cfg.base_delay);
            sat_next      = 1'b0;
            count_next    = attempt_number;
            decision_next = (attempt_number < cfg.retry_limit)
                          && class_retries(failure_class, cfg);
        end
        else if (cmd.step)
        begin
            count_next = count_reg - ATTEMPT_BITS'(1);
            if (overflow)
            begin
                delay_next = '1;
                sat_next   = 1'b1;
            end
            else
            begin
                delay_next = scaled[DELAY_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cmd.cap && cfg.jitter_enable)
        begin
            lfsr_next = lfsr_shifted;
        end
    end

    always_comb
    begin
        wait_next = wait_reg;
        if (cmd.jitter)
        begin
            if (cfg.jitter_enable)
            begin
                wait_next = jitter_sum[JIT_BITS-1:LFSR_BITS+1];
            end
            else
            begin
                wait_next = capped_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delay_reg    <= delay_next;
        sat_reg      <= sat_next;
        count_reg    <= count_next;
        decision_reg <= decision_next;
        wait_reg     <= wait_next;
        if (cmd.cap)
        begin
            capped_reg <= capped_next;
        end
        if (cmd.out_load)
        begin
            retry_allowed_reg <= decision_reg;
            wait_ms_reg       <= wait_reg;
        end
    end

    assign status.steps_done = (count_reg == '0) || sat_reg;
    assign retry_allowed     = retry_allowed_reg;
    assign wait_ms           = wait_ms_reg;

`ifndef NO_ASSERTIONS
    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("jitter LFSR reached the all-zero lockup state");

    a_sat_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && overflow) |=> (sat_reg && (delay_reg == '1)))
        else $error("saturated delay is not held at full scale");
`endif

endmodule

@@ rtl/retry_decision_backoff.sv @@
// Top level of the retry decision and capped exponential backoff block.
// Usage: an item beat (failure_class, attempt_number) is taken when item_valid
// is high and item_stall is low. The block answers with one result beat
// (retry_allowed, wait_ms) on result_valid, held until result_stall is low.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data. The user must write them only while no item is in
// flight; the block itself does not enforce this. cfg_ready is always high.
// One item is processed at a time: a new item is accepted only after the
// last one has been loaded into the output register. Each item runs the
// growth loop, one step per attempt until the delay saturates, with one
// multiply per cycle through its own multiplier, followed by a cap, a
// jitter multiply on a separate multiplier and the output load. A
// finished result waits in the output register while the next item is
// accepted; when the receiver stalls, the next item completes and waits in
// the completion state until the output register is free. Reset restores
// the documented register defaults, seeds the jitter LFSR and empties the
// output register.
module retry_decision_backoff
    import rdb_pkg::*;
#(
    parameter int DELAY_BITS       = DELAY_BITS_DEF,
    parameter int FACTOR_FRAC_BITS = FACTOR_FRAC_BITS_DEF,
    parameter int LFSR_BITS        = LFSR_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_stall,
    input  logic [CLASS_BITS-1:0]     failure_class,
    input  logic [ATTEMPT_BITS-1:0]   attempt_number,
    output logic                      result_valid,
    input  logic                      result_stall,
    output logic                      retry_allowed,
    output logic [WAIT_BITS-1:0]      wait_ms,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_RETRY_LIMIT:         cfg_next.retry_limit         = cfg_data[LIMIT_BITS-1:0];
                REG_THROTTLE_ENABLE:     cfg_next.throttle_enable     = cfg_data[0];
                REG_SERVER_ERROR_ENABLE: cfg_next.server_error_enable = cfg_data[0];
                REG_TIMEOUT_ENABLE:      cfg_next.timeout_enable      = cfg_data[0];
                REG_BASE_DELAY:          cfg_next.base_delay          = cfg_data[BASE_BITS-1:0];
                REG_GROWTH_FACTOR:       cfg_next.growth_factor       = cfg_data[FACTOR_BITS-1:0];
                REG_DELAY_CEILING:       cfg_next.delay_ceiling       = cfg_data[WAIT_BITS-1:0];
                REG_JITTER_ENABLE:       cfg_next.jitter_enable       = cfg_data[0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rdb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    rdb_datapath #(
        .DELAY_BITS       (DELAY_BITS),
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
        .LFSR_BITS        (LFSR_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .status         (status),
        .failure_class  (failure_class),
        .attempt_number (attempt_number),
        .retry_allowed  (retry_allowed),
        .wait_ms        (wait_ms)
    );

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the retry decision and capped exponential backoff block.
`timescale 1ns / 1ps

module tb;
    import rdb_pkg::*;

    localparam int          FRAC_BITS   = 8;
    localparam int          NOISE_BITS  = 16;
    localparam logic [15:0] NOISE_TAPS  = 16'hB400;
    localparam logic [15:0] NOISE_SEED  = 16'hACE1;
    localparam logic [63:0] NOISE_SPAN  = 64'd1 << NOISE_BITS;
    localparam logic [63:0] DELAY_FULL  = (64'd1 << 24) - 64'd1;
    localparam int          CYCLE_LIMIT = 2000000;
    localparam int          PHASES      = 9;
    localparam int          PHASE_ITEMS = 180;

    localparam logic [CLASS_BITS-1:0] CLS_UNKNOWN_LOW = 4'd11;
    localparam logic [CLASS_BITS-1:0] CLS_UNKNOWN_TOP = 4'd15;

    typedef struct {
        logic [LIMIT_BITS-1:0]  retry_limit;
        logic                   throttle_en;
        logic                   server_en;
        logic                   timeout_en;
        logic [BASE_BITS-1:0]   base_delay;
        logic [FACTOR_BITS-1:0] growth;
        logic [WAIT_BITS-1:0]   ceiling;
        logic                   jitter_en;
    } policy_t;

    typedef struct {
        logic                 retry;
        logic [WAIT_BITS-1:0] delay_ms;
    } decision_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    logic [CLASS_BITS-1:0]     failure_class;
    logic [ATTEMPT_BITS-1:0]   attempt_number;
    logic                      result_valid;
    logic                      result_stall;
    logic                      retry_allowed;
    logic [WAIT_BITS-1:0]      wait_ms;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    policy_t     policy;
    logic [15:0] noise;
    decision_t   decisions_due[$];
    bit          idling = 1'b1;
    int          cycles = 0;
    int          errors = 0;
    int          requests_taken = 0;
    int          decisions_checked = 0;
    int          retries_granted = 0;
    int          reg_writes = 0;

    retry_decision_backoff DUT (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    always
    begin : result_backpressure
        @(posedge clk);
        if (idling && $urandom_range(0, 4) == 0)
        begin
            result_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    function automatic void reset_policy();
        policy.retry_limit = 8'd3;
        policy.throttle_en = 1'b1;
        policy.server_en   = 1'b1;
        policy.timeout_en  = 1'b1;
        policy.base_delay  = 16'd100;
        policy.growth      = 12'd512;
        policy.ceiling     = 24'd20000;
        policy.jitter_en   = 1'b1;
        noise              = NOISE_SEED;
    endfunction

    function automatic void apply_register(input cfg_index_e idx,
                                           input logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            REG_RETRY_LIMIT:         policy.retry_limit = v[LIMIT_BITS-1:0];
            REG_THROTTLE_ENABLE:     policy.throttle_en = v[0];
            REG_SERVER_ERROR_ENABLE: policy.server_en   = v[0];
            REG_TIMEOUT_ENABLE:      policy.timeout_en  = v[0];
            REG_BASE_DELAY:          policy.base_delay  = v[BASE_BITS-1:0];
            REG_GROWTH_FACTOR:       policy.growth      = v[FACTOR_BITS-1:0];
            REG_DELAY_CEILING:       policy.ceiling     = v[WAIT_BITS-1:0];
            REG_JITTER_ENABLE:       policy.jitter_en   = v[0];
            default:                 ;
        endcase
        reg_writes++;
    endfunction

    function automatic logic class_may_retry(input logic [CLASS_BITS-1:0] cls);
        if (cls == CLS_TRANSPORT)
            return 1'b1;
        if (cls == CLS_SLOW_DOWN || cls == CLS_UNAVAILABLE)
            return policy.throttle_en;
        if (cls >= CLS_HTTP_500 && cls <= CLS_HTTP_504)
            return policy.server_en;
        if (cls >= CLS_TIMEOUT && cls <= CLS_CONN_FAILED)
            return policy.timeout_en;
        return 1'b0;
    endfunction

    // Works out one decision and moves the jitter generator on when jitter is enabled.
    function automatic decision_t forecast_decision(input logic [CLASS_BITS-1:0] cls,
                                                    input logic [ATTEMPT_BITS-1:0] att);
        decision_t   r;
        logic [63:0] d;
        logic [15:0] n;
        logic        sat;
        int          i;
        r.retry = (att < policy.retry_limit) && class_may_retry(cls);
        d = 64'(policy.base_delay);
        sat = 1'b0;
        for (i = 0; i < att && !sat; i++)
        begin
            d = (d * policy.growth) >> FRAC_BITS;
            if (d > DELAY_FULL)
            begin
                d = DELAY_FULL;
                sat = 1'b1;
            end
        end
        if (d > policy.ceiling)
            d = 64'(policy.ceiling);
        if (policy.jitter_en)
        begin
            n = noise >> 1;
            if (noise[0])
                n = n ^ NOISE_TAPS;
            if (n == 16'd0)
                n = NOISE_SEED;
            noise = n;
            d = (d * (NOISE_SPAN + noise)) >> (NOISE_BITS + 1);
        end
        r.delay_ms = d[WAIT_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        decision_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index_e'(cfg_index), cfg_data);
            if (item_valid && !item_stall)
            begin
                decisions_due.push_back(forecast_decision(failure_class, attempt_number));
                requests_taken++;
            end
            if (result_valid && !result_stall)
            begin
                if (decisions_due.size() == 0)
                begin
                    $error("result beat with no request outstanding: retry_allowed %0d wait_ms %0d",
                           retry_allowed, wait_ms);
                    errors++;
                end
                else
                begin
                    want = decisions_due.pop_front();
                    decisions_checked++;
                    if (retry_allowed)
                        retries_granted++;
                    if (retry_allowed !== want.retry)
                    begin
                        $error("retry_allowed: expected %0d, got %0d", want.retry, retry_allowed);
                        errors++;
                    end
                    if (wait_ms !== want.delay_ms)
                    begin
                        $error("wait_ms: expected %0d, got %0d", want.delay_ms, wait_ms);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_request(input logic [CLASS_BITS-1:0] cls,
                                input logic [ATTEMPT_BITS-1:0] att);
        cfg_valid <= 1'b0;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        failure_class  <= cls;
        attempt_number <= att;
        item_valid     <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        cfg_valid  <= 1'b0;
        do
            @(posedge clk);
        while (decisions_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_BITS-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_policy(input logic [LIMIT_BITS-1:0] lim, input logic thr,
                                  input logic srv, input logic tmo,
                                  input logic [BASE_BITS-1:0] base,
                                  input logic [FACTOR_BITS-1:0] factor,
                                  input logic [WAIT_BITS-1:0] ceil, input logic jit);
        wait_idle();
        write_reg(REG_RETRY_LIMIT, CFG_DATA_BITS'(lim));
        write_reg(REG_THROTTLE_ENABLE, CFG_DATA_BITS'(thr));
        write_reg(REG_SERVER_ERROR_ENABLE, CFG_DATA_BITS'(srv));
        write_reg(REG_TIMEOUT_ENABLE, CFG_DATA_BITS'(tmo));
        write_reg(REG_BASE_DELAY, CFG_DATA_BITS'(base));
        write_reg(REG_GROWTH_FACTOR, CFG_DATA_BITS'(factor));
        write_reg(REG_DELAY_CEILING, ceil);
        write_reg(REG_JITTER_ENABLE, CFG_DATA_BITS'(jit));
    endtask

    task automatic test_reset_defaults();
        send_request(CLS_TRANSPORT, 8'd0);
        send_request(CLS_TRANSPORT, 8'd2);
        send_request(CLS_TRANSPORT, 8'd3);
    endtask

    task automatic test_failure_classes();
        send_request(CLS_OTHER, 8'd0);
        send_request(CLS_SLOW_DOWN, 8'd0);
        send_request(CLS_UNAVAILABLE, 8'd1);
        send_request(CLS_HTTP_500, 8'd0);
        send_request(CLS_HTTP_502, 8'd1);
        send_request(CLS_HTTP_503, 8'd2);
        send_request(CLS_HTTP_504, 8'd0);
        send_request(CLS_TIMEOUT, 8'd0);
        send_request(CLS_REQ_TIMEOUT, 8'd1);
        send_request(CLS_CONN_FAILED, 8'd2);
        send_request(CLS_UNKNOWN_LOW, 8'd0);
        send_request(CLS_UNKNOWN_TOP, 8'd0);
        program_policy(8'd3, 1'b0, 1'b0, 1'b0, 16'd100, 12'd512, 24'd20000, 1'b1);
        send_request(CLS_UNAVAILABLE, 8'd0);
        send_request(CLS_HTTP_503, 8'd0);
        send_request(CLS_REQ_TIMEOUT, 8'd0);
    endtask

    task automatic test_delay_extremes();
        program_policy(8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 1'b0);
        send_request(CLS_TRANSPORT, 8'd255);
        send_request(CLS_TRANSPORT, 8'd254);
        program_policy(8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 12'd256, 24'hFFFFFF, 1'b1);
        send_request(CLS_TRANSPORT, 8'd255);
        program_policy(8'd0, 1'b1, 1'b1, 1'b1, 16'd0, 12'd0, 24'd0, 1'b1);
        send_request(CLS_TRANSPORT, 8'd0);
        program_policy(8'd5, 1'b1, 1'b1, 1'b1, 16'd1000, 12'd0, 24'hFFFFFF, 1'b1);
        send_request(CLS_HTTP_500, 8'd0);
        send_request(CLS_HTTP_500, 8'd1);
    endtask

    task automatic test_random_traffic(input int phases, input int items);
        logic [LIMIT_BITS-1:0]  lim;
        logic [BASE_BITS-1:0]   base;
        logic [FACTOR_BITS-1:0] factor;
        logic [WAIT_BITS-1:0]   ceil;
        logic [CLASS_BITS-1:0]  cls;
        logic [ATTEMPT_BITS-1:0] att;
        int p;
        int k;
        int r;
        int near;
        for (p = 0; p < phases; p++)
        begin
            if (p == 0)
                program_policy(8'hFF, 1'b1, 1'b1, 1'b1, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 1'b1);
            else if (p == 1)
                program_policy(8'd0, 1'b0, 1'b0, 1'b0, 16'd0, 12'd0, 24'd0, 1'b0);
            else
            begin
                r = $urandom_range(0, 3);
                lim = (r == 0) ? 8'hFF : (r == 1) ? 8'd0 : 8'($urandom_range(1, 12));
                r = $urandom_range(0, 3);
                base = (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0
                     : (r == 2) ? 16'($urandom_range(1, 2000)) : 16'($urandom);
                r = $urandom_range(0, 4);
                factor = (r == 0) ? 12'hFFF : (r == 1) ? 12'd0 : (r == 2) ? 12'd256
                       : (r == 3) ? 12'($urandom_range(200, 1024)) : 12'($urandom);
                r = $urandom_range(0, 3);
                ceil = (r == 0) ? 24'hFFFFFF : (r == 1) ? 24'd0
                     : (r == 2) ? 24'($urandom_range(1, 100000)) : 24'($urandom);
                program_policy(lim, 1'($urandom), 1'($urandom), 1'($urandom), base, factor,
                               ceil, $urandom_range(0, 3) != 0);
            end
            if (items < PHASE_ITEMS)
                idling = 1'b0;
            else
                idling = $urandom_range(0, 3) != 0;
            for (k = 0; k < items; k++)
            begin
                r = $urandom_range(0, 9);
                cls = (r < 9) ? 4'($urandom_range(0, 10)) : 4'($urandom_range(11, 15));
                r = $urandom_range(0, 9);
                if (r < 6)
                    att = 8'($urandom_range(0, 15));
                else if (r < 9)
                begin
                    near = int'(policy.retry_limit) + int'($urandom_range(0, 2)) - 1;
                    if (near < 0)
                        near = 0;
                    if (near > 255)
                        near = 255;
                    att = 8'(near);
                end
                else
                    att = 8'($urandom_range(0, 255));
                send_request(cls, att);
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        failure_class  = '0;
        attempt_number = '0;
        result_stall   = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        reset_policy();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_failure_classes();
        test_delay_extremes();
        test_random_traffic(PHASES, PHASE_ITEMS);
        test_random_traffic(3, 40);

        wait_idle();
        repeat (300) @(posedge clk);
        if (decisions_due.size() != 0)
        begin
            $error("%0d decisions never arrived", decisions_due.size());
            errors++;
        end
        $display("Ran %0d retry requests under %0d register writes over %0d cycles.",
                 requests_taken, reg_writes, cycles);
        $display("Checked %0d decisions, %0d granting a retry; %0d mismatches.",
                 decisions_checked, retries_granted, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
